// ----- design/tvbs_pkg.sv -----
// ----------------------------------------------------------------------------
// tvbs_pkg: shared types and constants for the typed value byte serializer
// Selector codes, controller state, and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tvbs_pkg;

  // Value and beat widths
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 64;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned CNT_W   = 4;   // holds 1 to 10 bytes per item
  localparam int unsigned GROUP_W = 7;
  localparam int unsigned GROUPS_MAX = 10;
  localparam int unsigned WIDE_W  = GROUP_W * GROUPS_MAX;

  localparam logic [GROUP_W-1:0] GROUP_MASK = 7'h7f;
  localparam logic [BYTE_W-1:0]  CONT_BIT   = 8'h80;
  localparam logic [BYTE_W-1:0]  BYTE_MASK  = 8'hff;

  // Type selector codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_BYTE     = 3'd0,
    FUNC_FIXED32  = 3'd1,
    FUNC_FIXED64  = 3'd2,
    FUNC_VARINT32 = 3'd3,
    FUNC_VARINT64 = 3'd4
  } func_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the input value and byte count
    logic emit;   // move the next byte into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic func_ok;    // selector names a known form
    logic last_byte;  // one byte left in the current item
    logic slot_free;  // output register empty or being taken
  } sts_t;

endpackage

// ----- design/typed_value_byte_serializer_core.sv -----
// ----------------------------------------------------------------------------
// typed_value_byte_serializer_core: typed value to byte stream
// Encodes one value per input beat as a raw byte, 32/64-bit big-endian
// word, or MSB-first 7-bit varint, one output beat per byte, each
// tagged with its running stream offset.
//
//   channel | direction | payload
//   --------+-----------+--------------------------------------------------
//   s_*     | in        | tuser: func[2:0]; tdata: value[63:0]
//   m_*     | out       | tdata: data_byte[7:0], byte_position[71:8];
//           |           | tlast: last byte of the item
//
// An item is accepted while idle, then its bytes pass one at a time
// through the single output beat register. An unknown selector is
// taken and yields nothing. Synchronous reset clears the stream offset
// and the controller. A stalled output holds the byte sequencer; the
// next input is accepted while the final byte still waits.
// ----------------------------------------------------------------------------
module typed_value_byte_serializer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic [2:0]  s_tuser,   // [2:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [7:0] data_byte, [71:8] byte_position
  output logic        m_tlast
);

  tvbs_pkg::cmd_t cmd;
  tvbs_pkg::sts_t sts;

  logic [tvbs_pkg::BYTE_W-1:0] data_byte;
  logic [tvbs_pkg::POS_W-1:0]  byte_position;

  tvbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tvbs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .func          (s_tuser),
    .value         (s_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .data_byte     (data_byte),
    .byte_position (byte_position),
    .last          (m_tlast)
  );

  assign m_tdata = {byte_position, data_byte};

  // A waiting non-final byte means the item is still being sent
  a_busy_mid_item: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("input ready while a non-final byte is pending");

  // Sending the final byte returns the controller to idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.last_byte) |=> s_tready)
    else $error("controller did not return to idle after final byte");

  // An unknown selector starts no byte run
  a_drop_unknown: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !sts.func_ok) |=> (s_tready && !cmd.emit))
    else $error("unknown selector started a byte run");

endmodule

// ----- design/tvbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tvbs_ctrl: serializer controller
// Two-state machine: take an item while idle, then step the datapath
// through its bytes whenever the output register can take one.
// ----------------------------------------------------------------------------
module tvbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  tvbs_pkg::sts_t   sts,
  output tvbs_pkg::cmd_t   cmd
);

  tvbs_pkg::state_t state;
  tvbs_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    unique case (state)
      tvbs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        // unknown selectors are taken and dropped
        if (s_tvalid && sts.func_ok) begin
          cmd.load   = 1'b1;
          state_next = tvbs_pkg::ST_EMIT;
        end
      end
      tvbs_pkg::ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last_byte) begin
            state_next = tvbs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = tvbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/tvbs_dp.sv -----
// ----------------------------------------------------------------------------
// tvbs_dp: serializer datapath
// Holds the masked value and remaining byte count, picks the next byte
// (fixed big-endian or 7-bit group), and keeps the output beat register
// and the running stream offset.
// ----------------------------------------------------------------------------
module tvbs_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [tvbs_pkg::FUNC_W-1:0]         func,
  input  logic [tvbs_pkg::VALUE_W-1:0]        value,
  input  tvbs_pkg::cmd_t                      cmd,
  output tvbs_pkg::sts_t                      sts,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tvbs_pkg::BYTE_W-1:0]         data_byte,
  output logic [tvbs_pkg::POS_W-1:0]          byte_position,
  output logic                                last
);

  tvbs_pkg::func_t                   func_in;
  logic [tvbs_pkg::VALUE_W-1:0]      value_mask;
  logic [tvbs_pkg::WIDE_W-1:0]       value_wide;
  logic [tvbs_pkg::CNT_W-1:0]        groups;
  logic [tvbs_pkg::CNT_W-1:0]        fix_count;
  logic [tvbs_pkg::CNT_W-1:0]        count_load;
  logic                              varint_load;
  logic                              func_ok;

  logic [tvbs_pkg::VALUE_W-1:0]      val;
  logic                              varint;
  logic [tvbs_pkg::CNT_W-1:0]        remaining;
  logic [tvbs_pkg::CNT_W-1:0]        idx;
  logic [tvbs_pkg::GROUP_W-1:0]      grp;
  logic [tvbs_pkg::BYTE_W-1:0]       fix_byte;
  logic [tvbs_pkg::BYTE_W-1:0]       next_byte;
  logic                              is_last;
  logic [tvbs_pkg::POS_W-1:0]        offset;

  assign func_in = tvbs_pkg::func_t'(func);

  // Decode selector: mask narrow forms, pick fixed byte count
  always_comb begin
    value_mask  = value;
    fix_count   = 4'd1;
    varint_load = 1'b0;
    func_ok     = 1'b1;
    unique case (func_in)
      tvbs_pkg::FUNC_BYTE: begin
        value_mask = {56'b0, value[7:0]};
        fix_count  = 4'd1;
      end
      tvbs_pkg::FUNC_FIXED32: begin
        value_mask = {32'b0, value[31:0]};
        fix_count  = 4'd4;
      end
      tvbs_pkg::FUNC_FIXED64: begin
        fix_count = 4'd8;
      end
      tvbs_pkg::FUNC_VARINT32: begin
        value_mask  = {32'b0, value[31:0]};
        varint_load = 1'b1;
      end
      tvbs_pkg::FUNC_VARINT64: begin
        varint_load = 1'b1;
      end
      default: begin
        func_ok = 1'b0;
      end
    endcase
  end

  // Count 7-bit groups up to the highest nonzero one, at least one
  always_comb begin
    value_wide = {{(tvbs_pkg::WIDE_W - tvbs_pkg::VALUE_W){1'b0}}, value_mask};
    groups     = 4'd1;
    for (int g = 1; g < tvbs_pkg::GROUPS_MAX; g++) begin
      if (value_wide[g*tvbs_pkg::GROUP_W +: tvbs_pkg::GROUP_W] != '0) begin
        groups = tvbs_pkg::CNT_W'(g + 1);
      end
    end
  end

  assign count_load = varint_load ? groups : fix_count;

  // Capture item, count down bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (cmd.load) begin
      remaining <= count_load;
    end else if (cmd.emit) begin
      remaining <= remaining - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val    <= value_mask;
      varint <= varint_load;
    end
  end

  // Select next byte, most significant part first
  assign idx      = remaining - 4'd1;
  assign is_last  = (remaining == 4'd1);
  assign grp      = tvbs_pkg::GROUP_MASK
                    & tvbs_pkg::GROUP_W'(val >> (7'(idx) * 7'd7));
  assign fix_byte = tvbs_pkg::BYTE_MASK & tvbs_pkg::BYTE_W'(val >> {idx, 3'b000});
  assign next_byte = varint ? ({1'b0, grp} | (is_last ? 8'h00 : tvbs_pkg::CONT_BIT))
                            : fix_byte;

  // Output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      data_byte     <= next_byte;
      byte_position <= offset;
      last          <= is_last;
    end
  end

  // Advance the stream offset, wrapping at 2^64
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cmd.emit) begin
      offset <= offset + 64'd1;
    end
  end

  assign sts.func_ok   = func_ok;
  assign sts.last_byte = is_last;
  assign sts.slot_free = !m_tvalid || m_tready;

endmodule

// ----- tb/sv/typed_value_byte_serializer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_value_byte_serializer_core_tb: self-checking bench for the serializer
// Sends typed values through the input stream: first a table of directed
// cases, many with their byte run written out, then random values of all
// forms. The rest are checked against an in-bench encoder that also tracks
// the running stream offset. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module typed_value_byte_serializer_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned GAP_MAX      = 11;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Selector codes the block must ignore
  localparam logic [tvbs_pkg::FUNC_W-1:0] SEL_SPARE_5 = 3'd5;
  localparam logic [tvbs_pkg::FUNC_W-1:0] SEL_SPARE_6 = 3'd6;
  localparam logic [tvbs_pkg::FUNC_W-1:0] SEL_SPARE_7 = 3'd7;

  // One expected output beat
  typedef struct packed {
    logic [tvbs_pkg::BYTE_W-1:0] data;
    logic [tvbs_pkg::POS_W-1:0]  pos;
    logic                        last;
  } out_beat_t;

  // One directed case; bytes holds the run right-aligned, first byte leftmost
  typedef struct packed {
    logic [tvbs_pkg::FUNC_W-1:0]  sel;
    logic [tvbs_pkg::VALUE_W-1:0] value;
    logic                         typed;
    logic [tvbs_pkg::CNT_W-1:0]   nbytes;
    logic [79:0]                  bytes;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [63:0] value
  logic [2:0]  s_tuser = '0;   // [2:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [7:0] data_byte, [71:8] byte_position
  logic        m_tlast;

  out_beat_t                  pending_bytes [$];
  logic [tvbs_pkg::POS_W-1:0] stream_pos = '0;
  int unsigned                mismatch_count = 0;
  int unsigned                cycle_count = 0;
  int unsigned                tx_gap_max = GAP_MAX;
  int unsigned                rx_gap_max = GAP_MAX;
  dir_row_t                   dir_rows [$];

  typed_value_byte_serializer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("typed_value_byte_serializer_core_tb: errors");
      $finish;
    end
  end

  // Encode one accepted value and queue its bytes at the running offset
  task automatic queue_encoding(input logic [tvbs_pkg::FUNC_W-1:0]  sel,
                                input logic [tvbs_pkg::VALUE_W-1:0] v);
    logic [tvbs_pkg::VALUE_W-1:0] word;
    logic [tvbs_pkg::VALUE_W-1:0] rest;
    logic [tvbs_pkg::BYTE_W-1:0]  b;
    int                           n;
    bit                           vlq;
    word = v;
    n    = 0;
    vlq  = 1'b0;
    case (sel)
      tvbs_pkg::FUNC_BYTE:     begin word = {56'd0, v[7:0]};  n = 1; end
      tvbs_pkg::FUNC_FIXED32:  begin word = {32'd0, v[31:0]}; n = 4; end
      tvbs_pkg::FUNC_FIXED64:  begin n = 8; end
      tvbs_pkg::FUNC_VARINT32: begin word = {32'd0, v[31:0]}; vlq = 1'b1; end
      tvbs_pkg::FUNC_VARINT64: begin vlq = 1'b1; end
      default:                 n = 0;
    endcase
    // Count 7-bit groups, keeping at least one
    if (vlq) begin
      n    = 1;
      rest = word >> tvbs_pkg::GROUP_W;
      while (rest != 0) begin
        n++;
        rest = rest >> tvbs_pkg::GROUP_W;
      end
    end
    for (int k = 0; k < n; k++) begin
      if (vlq) begin
        b = {1'b0, tvbs_pkg::GROUP_MASK
                   & tvbs_pkg::GROUP_W'(word >> (tvbs_pkg::GROUP_W * (n - 1 - k)))};
        if (k != n - 1) b = b | tvbs_pkg::CONT_BIT;
      end else begin
        b = word[tvbs_pkg::BYTE_W*(n-1-k) +: tvbs_pkg::BYTE_W];
      end
      pending_bytes.push_back('{b, stream_pos, k == n - 1});
      stream_pos = stream_pos + 1;
    end
  endtask

  // Offer one value after a random gap and hold it until taken
  task automatic send_value(input logic [tvbs_pkg::FUNC_W-1:0]  sel,
                            input logic [tvbs_pkg::VALUE_W-1:0] v);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      s_tuser  <= 3'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= sel;
    do @(posedge clk); while (!s_tready);
  endtask

  // Draw a value whose size spreads over all group counts
  function automatic logic [tvbs_pkg::VALUE_W-1:0] draw_value();
    logic [tvbs_pkg::VALUE_W-1:0] v;
    int unsigned                  k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2: draw_value = v;
      3: begin
        k = $urandom_range(0, 9);
        draw_value = (64'd1 << (tvbs_pkg::GROUP_W * k)) - 64'($urandom_range(0, 1));
      end
      4:       draw_value = $urandom_range(0, 1) ? '1 : '0;
      default: draw_value = v >> $urandom_range(0, 63);
    endcase
  endfunction

  // Check each output beat against the oldest expectation
  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected beat: data_byte %h byte_position %h last %b",
               m_tdata[7:0], m_tdata[71:8], m_tlast);
        mismatch_count++;
      end else begin
        exp_beat = pending_bytes.pop_front();
        if (m_tdata[7:0] !== exp_beat.data) begin
          $error("data_byte: expected %h, got %h", exp_beat.data, m_tdata[7:0]);
          mismatch_count++;
        end
        if (m_tdata[71:8] !== exp_beat.pos) begin
          $error("byte_position: expected %h, got %h", exp_beat.pos, m_tdata[71:8]);
          mismatch_count++;
        end
        if (m_tlast !== exp_beat.last) begin
          $error("last: expected %b, got %b", exp_beat.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Stall the output side for a random number of cycles per beat
  initial begin
    int unsigned stall;
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Directed cases, then random values
  initial begin
    dir_row_t                    row;
    logic [tvbs_pkg::FUNC_W-1:0] sel;
    int unsigned                 sent;
    int unsigned                 pick;

    // Extremes, every form, narrow forms with junk above, spare selectors
    dir_rows.push_back('{tvbs_pkg::FUNC_BYTE,     64'h0,                 1'b1, 4'd1,
                         80'h00});
    dir_rows.push_back('{tvbs_pkg::FUNC_BYTE,     64'hFFFF_FFFF_FFFF_FF5A, 1'b1, 4'd1,
                         80'h5A});
    dir_rows.push_back('{tvbs_pkg::FUNC_BYTE,     64'hFF,                1'b1, 4'd1,
                         80'hFF});
    dir_rows.push_back('{tvbs_pkg::FUNC_FIXED32,  64'h0,                 1'b1, 4'd4,
                         80'h00000000});
    dir_rows.push_back('{tvbs_pkg::FUNC_FIXED32,  64'hFFFF_FFFF_1234_5678, 1'b1, 4'd4,
                         80'h12345678});
    dir_rows.push_back('{tvbs_pkg::FUNC_FIXED32,  64'hFFFF_FFFF,         1'b1, 4'd4,
                         80'hFFFFFFFF});
    dir_rows.push_back('{tvbs_pkg::FUNC_FIXED32,  64'hDEAD_BEEF,         1'b1, 4'd4,
                         80'hDEADBEEF});
    dir_rows.push_back('{tvbs_pkg::FUNC_FIXED64,  64'h0123_4567_89AB_CDEF, 1'b1, 4'd8,
                         80'h0123456789ABCDEF});
    dir_rows.push_back('{tvbs_pkg::FUNC_FIXED64,  '1,                    1'b1, 4'd8,
                         80'hFFFFFFFFFFFFFFFF});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT32, 64'h0,                 1'b1, 4'd1,
                         80'h00});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT32, 64'h7F,                1'b1, 4'd1,
                         80'h7F});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT32, 64'h80,                1'b1, 4'd2,
                         80'h8100});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT32, 64'hFFFF_FFFF_0000_0000, 1'b1, 4'd1,
                         80'h00});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT32, 64'hFFFF_FFFF,         1'b1, 4'd5,
                         80'h8FFFFFFF7F});
    dir_rows.push_back('{SEL_SPARE_5,             64'h1234,              1'b1, 4'd0,
                         80'h0});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT64, 64'h0,                 1'b1, 4'd1,
                         80'h00});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT64, 64'h3FFF,              1'b1, 4'd2,
                         80'hFF7F});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT64, 64'h4000,              1'b1, 4'd3,
                         80'h818000});
    dir_rows.push_back('{SEL_SPARE_6,             '1,                    1'b1, 4'd0,
                         80'h0});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT64, '1,                    1'b1, 4'd10,
                         80'h81FFFFFFFFFFFFFFFF7F});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT64, 64'h8000_0000_0000_0000, 1'b1, 4'd10,
                         80'h81808080808080808000});
    dir_rows.push_back('{SEL_SPARE_7,             64'h0,                 1'b1, 4'd0,
                         80'h0});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT64, 64'h1234_5678_9ABC_DEF0, 1'b0, 4'd0,
                         80'h0});
    dir_rows.push_back('{tvbs_pkg::FUNC_VARINT32, 64'h0FED_CBA9_8765_4321, 1'b0, 4'd0,
                         80'h0});

    // Hold reset, release on a rising edge
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_value(row.sel, row.value);
      if (row.typed) begin
        for (int k = 0; k < row.nbytes; k++) begin
          pending_bytes.push_back(
            '{row.bytes[tvbs_pkg::BYTE_W*(row.nbytes-1-k) +: tvbs_pkg::BYTE_W],
              stream_pos, k == row.nbytes - 1});
          stream_pos = stream_pos + 1;
        end
      end else begin
        queue_encoding(row.sel, row.value);
      end
    end

    // Random values; pacing changes every few dozen items, bursts included
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 30 == 0) begin
        pick = $urandom_range(0, 3);
        tx_gap_max = (pick == 0) ? 0 : (pick == 1) ? 2 : GAP_MAX;
        pick = $urandom_range(0, 3);
        rx_gap_max = (pick == 0) ? 0 : (pick == 1) ? 2 : GAP_MAX;
      end
      if ($urandom_range(0, 12) == 0) begin
        sel = 3'($urandom_range(5, 7));
      end else begin
        sel = 3'($urandom_range(0, 4));
        sent++;
      end
      send_value(sel, draw_value());
      queue_encoding(sel, s_tdata);
    end
    s_tvalid <= 1'b0;

    // Drain, then allow stray beats to show up
    tx_gap_max = GAP_MAX;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("typed_value_byte_serializer_core_tb: clean");
    end else begin
      $display("typed_value_byte_serializer_core_tb: errors");
    end
    $finish;
  end

endmodule
